FILE: hw/rtl/ffba_pkg.sv
package ffba_pkg;

   // Map geometry
   localparam int MAP_BITS    = 4096;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = MAP_BITS / WORD_BITS;
   localparam int WADDR_W     = $clog2(MAP_WORDS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int GROUP_WORDS = 8;
   localparam int GROUPS      = MAP_WORDS / GROUP_WORDS;
   localparam int GROUP_W     = $clog2(GROUPS);
   localparam int SLOT_W      = $clog2(GROUP_WORDS);

   // Field widths
   localparam int IDX_W     = 12;
   localparam int CNT_W     = 13;
   localparam int CSR_IDX_W = 1;

   localparam int COUNT_MAX_INT = 8191;
   localparam logic [CNT_W-1:0] COUNT_CAP =
      CNT_W'((MAP_BITS < COUNT_MAX_INT) ? MAP_BITS : COUNT_MAX_INT);
   localparam logic [CNT_W-1:0] CSR_RESET  = CNT_W'(4096);
   localparam logic [CNT_W-1:0] FREE_RESET = (CSR_RESET < COUNT_CAP) ? CSR_RESET : COUNT_CAP;
   localparam logic [IDX_W:0]   MAP_LIMIT  = (IDX_W + 1)'(MAP_BITS);

   // Item kinds
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_MARK  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_AT_START = 1'd1;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_IGNORED  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] block_num;
   } req_word_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] granted_index;
      logic [CNT_W-1:0] free_count;
   } rsp_word_type;

endpackage

FILE: hw/rtl/ffba_ifs.sv
interface ffba_req_if;
   import ffba_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ffba_rsp_if;
   import ffba_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/first_free_bitmap_block_allocator.sv
// Channel    Dir  Handshake          Word
// req_chan   in   valid/ready        kind, block_num
// rsp_chan   out  valid/ready        status, granted_index, free_count
// csr_*      in   csr_wr_en (no ack) csr_index, csr_wr_data
//
// Allocate runs search, modify and reply states between accepts, free and mark only modify
// and reply: one map-RAM read and one write-back per word, plus the search state for the
// two-level first-fit search over per-row full flags (allocate only).
// Result register is separate: a new word is accepted while a result waits.
// A finished item holds in the reply state while that register is still full.
// Synchronous reset; the map needs no clearing pass: per-row valid flags make
// unwritten rows read as all free.
module first_free_bitmap_block_allocator (
   input  logic                          clock,
   input  logic                          reset,
   ffba_req_if.sink                      req_chan,
   ffba_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [ffba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ffba_pkg::CNT_W-1:0]    csr_wr_data
);
   import ffba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MODIFY,
      ST_REPLY
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [MAP_WORDS-1:0] row_valid_ff, row_valid_in;
   logic [MAP_WORDS-1:0] row_full_ff, row_full_in;

   // payload
   logic [1:0]           kind_ff, kind_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [WADDR_W-1:0]   scan_word_ff, scan_word_in;
   logic                 scan_hit_ff, scan_hit_in;
   logic [GROUPS-1:0]    grp_open_ff, grp_open_in;
   logic                 rd_valid_ff;
   rsp_word_type         res_ff, res_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;

   // map RAM
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WADDR_W-1:0]   rd_addr;
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // search / modify helpers
   logic [GROUP_W-1:0]     pick_grp;
   logic [SLOT_W-1:0]      pick_slot;
   logic [GROUP_WORDS-1:0] grp_full;
   logic [WORD_BITS-1:0]   cur_word;
   logic [BIT_W-1:0]       zero_bit;
   logic [IDX_W-1:0]       alloc_idx;
   logic [WORD_BITS-1:0]   alloc_mask;
   logic [WORD_BITS-1:0]   idx_mask;
   logic                   accept;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // group level of the first-fit search, refreshed every cycle
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_open_in[g] = ~&row_full_ff[g*GROUP_WORDS +: GROUP_WORDS];
      end
   end

   // lowest open group, then lowest non-full row in it
   always_comb begin
      pick_grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_open_ff[g]) begin
            pick_grp = GROUP_W'(g);
         end
      end
      grp_full  = row_full_ff[pick_grp*GROUP_WORDS +: GROUP_WORDS];
      pick_slot = '0;
      for (int s = GROUP_WORDS - 1; s >= 0; s--) begin
         if (!grp_full[s]) begin
            pick_slot = SLOT_W'(s);
         end
      end
   end

   // RAM read address: item's own row on accept, search pick otherwise
   assign rd_addr = (state_ff == ST_IDLE) ? req_chan.data.block_num[IDX_W-1:BIT_W]
                                          : {pick_grp, pick_slot};

   // lowest clear bit of the row read back
   assign cur_word = rd_valid_ff ? rd_data_ff : '0;
   always_comb begin
      zero_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!cur_word[b]) begin
            zero_bit = BIT_W'(b);
         end
      end
   end
   assign alloc_idx  = {scan_word_ff, zero_bit};
   assign alloc_mask = WORD_BITS'(1) << zero_bit;
   assign idx_mask   = WORD_BITS'(1) << idx_ff[BIT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      limit_in     = limit_ff;
      free_in      = free_ff;
      row_valid_in = row_valid_ff;
      row_full_in  = row_full_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      scan_word_in = scan_word_ff;
      scan_hit_in  = scan_hit_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_word_ff;
      wr_data      = cur_word;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in      = req_chan.data.kind;
               idx_in       = req_chan.data.block_num;
               scan_word_in = req_chan.data.block_num[IDX_W-1:BIT_W];
               state_in     = (req_chan.data.kind == KIND_ALLOC) ? ST_SEARCH : ST_MODIFY;
            end
         end
         ST_SEARCH: begin
            scan_hit_in  = |grp_open_ff;
            scan_word_in = {pick_grp, pick_slot};
            state_in     = ST_MODIFY;
         end
         ST_MODIFY: begin
            res_in.status        = STATUS_IGNORED;
            res_in.granted_index = idx_ff;
            case (kind_ff)
               KIND_ALLOC: begin
                  if (scan_hit_ff && (CNT_W'(alloc_idx) < limit_ff)) begin
                     wr_en                = 1'b1;
                     wr_data              = cur_word | alloc_mask;
                     free_in              = (free_ff != '0) ? free_ff - 1'b1 : free_ff;
                     res_in.status        = STATUS_DONE;
                     res_in.granted_index = alloc_idx;
                  end else begin
                     res_in.status        = STATUS_NO_SPACE;
                     res_in.granted_index = '0;
                  end
               end
               KIND_FREE: begin
                  if ((CNT_W'(idx_ff) < limit_ff) && cur_word[idx_ff[BIT_W-1:0]]) begin
                     wr_en         = 1'b1;
                     wr_data       = cur_word & ~idx_mask;
                     free_in       = (free_ff < COUNT_CAP) ? free_ff + 1'b1 : free_ff;
                     res_in.status = STATUS_DONE;
                  end
               end
               KIND_MARK: begin
                  if ((IDX_W + 1)'(idx_ff) < MAP_LIMIT) begin
                     wr_en         = 1'b1;
                     wr_data       = cur_word | idx_mask;
                     res_in.status = STATUS_DONE;
                  end
               end
               default: begin
                  res_in.status = STATUS_IGNORED;
               end
            endcase
            res_in.free_count = free_in;
            if (wr_en) begin
               row_valid_in[wr_addr] = 1'b1;
               row_full_in[wr_addr]  = &wr_data;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the user must write only while idle; the block itself does not enforce it
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCKS_IN_USE: limit_in = csr_wr_data;
            CSR_FREE_AT_START: free_in  = (csr_wr_data < COUNT_CAP) ? csr_wr_data : COUNT_CAP;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      scan_word_ff <= scan_word_in;
      scan_hit_ff  <= scan_hit_in;
      grp_open_ff  <= grp_open_in;
      rd_valid_ff  <= row_valid_ff[rd_addr];
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= CSR_RESET;
         free_ff      <= FREE_RESET;
         row_valid_ff <= '0;
         row_full_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         free_ff      <= free_in;
         row_valid_ff <= row_valid_in;
         row_full_ff  <= row_full_in;
      end
   end

   // map RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

endmodule

FILE: hw/rtl/ffba_checker.sv
module ffba_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic [ffba_pkg::IDX_W-1:0] rsp_granted,
   input logic [ffba_pkg::CNT_W-1:0] rsp_free
);
   import ffba_pkg::*;

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted) && $stable(rsp_free))
      else $error("stalled result word changed");

   // one item in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free <= COUNT_CAP)
      else $error("free count above cap");

   a_no_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NO_SPACE |-> rsp_granted == '0)
      else $error("no-space result with nonzero index");

endmodule

bind first_free_bitmap_block_allocator ffba_checker u_ffba_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.data.status),
   .rsp_granted (rsp_chan.data.granted_index),
   .rsp_free    (rsp_chan.data.free_count)
);
